// File: hdl/sdrms_pkg.sv
// Shared constants and types for the stereo downmix block RMS meter.
// Used by the level unit, the top level and the port checker.
package sdrms_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned BLOCKS_W       = 16;
  localparam int unsigned LEVEL_W        = 7;
  localparam int unsigned FRAMES_DEF     = 256;
  localparam int unsigned MAX_BLOCKS_RST = 7500;
  localparam int unsigned RMS_CLIP       = 3000;
  localparam int unsigned LEVEL_MAX      = 100;
  localparam int unsigned DIV30_MUL      = 2185;
  localparam int unsigned SQ_W           = 31;
  localparam int unsigned ROOT_W         = 16;
  localparam int unsigned ROOT_STEPS     = 16;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } lvl_stat_t;

endpackage

// File: hdl/stereo_downmix_block_rms_meter.sv
// Stereo downmix with block RMS level meter, top level.
// Instantiates sdrms_level_unit; depends on sdrms_pkg.
//
// Input stream: one stereo frame per item, tdata = {right, left}.
// Output stream: one result item per input item. tdata carries mono sample,
// level, completed block count and full flag; tlast marks the last frame of
// a block; tuser says the frame was recorded.
// Config channel: cfg_data_i sets the capacity in blocks, always ready.
//
// Timing: an ordinary frame passes the downmix, square and accumulate registers
// before its result is loaded into the output register, and input ready returns
// once it is loaded. The last frame of a block adds the level engine: 16 square
// root steps, then scaling and a handoff to the top level. One frame is in work
// at a time; input ready is low from accept until the result is loaded into the
// output register.
// Reset clears the sum, frame position, block count, level and full flag
// and loads a capacity of 7500 blocks. A stalled receiver holds the result
// in the output register; one further frame may be accepted and processed,
// and its result waits until the output register is free.
module stereo_downmix_block_rms_meter import sdrms_pkg::*; #(
  parameter int unsigned FRAMES_PER_BLOCK = FRAMES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // left_sample[15:0], right_sample[31:16]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // mono_sample[15:0], level[22:16],
                                              // blocks_recorded[38:23], full_res[39]
  output logic                m_axis_tlast,
  output logic [0:0]          m_axis_tuser,   // accepted[0]
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BLOCKS_W-1:0] cfg_data_i
);

  localparam int unsigned SUM_W = SQ_W + $clog2(FRAMES_PER_BLOCK);
  localparam int unsigned IDX_W = (FRAMES_PER_BLOCK > 1) ? $clog2(FRAMES_PER_BLOCK) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_ACC, S_LVL, S_OUT} state_e;

  state_e                      state_q;
  logic [BLOCKS_W-1:0]         max_blocks_q;
  logic [SUM_W-1:0]            sum_q;
  logic [IDX_W-1:0]            idx_q;
  logic [BLOCKS_W-1:0]         blocks_q;
  logic [LEVEL_W-1:0]          level_q;
  logic                        full_q;
  logic                        acc_q;
  logic                        done_q;
  logic                        m_valid_q;
  logic signed [SAMPLE_W-1:0]  mono_q;
  logic [SQ_W-1:0]             sq_q;
  logic [39:0]                 m_data_q;
  logic                        m_last_q;
  logic                        m_user_q;

  logic signed [SAMPLE_W:0]    pair_sum;
  logic signed [31:0]          sq_full;
  logic                        blk_start;
  logic                        over_cap;
  logic                        full_n;
  logic                        rec;
  logic                        last;
  logic [SUM_W-1:0]            sum_n;
  logic                        lvl_start;
  logic                        out_free;
  logic                        out_load;
  lvl_stat_t                   lvl_stat;

  assign pair_sum = SAMPLE_W'(signed'(s_axis_tdata[15:0])) + SAMPLE_W'(signed'(s_axis_tdata[31:16]));
  assign sq_full  = mono_q * mono_q;

  assign blk_start = (idx_q == '0);
  assign over_cap  = ({1'b0, blocks_q} + 17'd1) > {1'b0, max_blocks_q};
  assign full_n    = full_q | (blk_start & over_cap);
  assign rec       = ~full_n | ~blk_start;
  assign last      = (idx_q == IDX_W'(FRAMES_PER_BLOCK - 1));
  assign sum_n     = sum_q + SUM_W'(sq_q);
  assign lvl_start = (state_q == S_ACC) & rec & last;
  assign out_free  = ~m_valid_q | m_axis_tready;
  assign out_load  = (state_q == S_OUT) & out_free;

  sdrms_level_unit #(
    .FRAMES_PER_BLOCK(FRAMES_PER_BLOCK)
  ) u_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(lvl_start),
    .sum_i  (sum_n),
    .stat_o (lvl_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_blocks_q <= BLOCKS_W'(MAX_BLOCKS_RST);
      sum_q        <= '0;
      idx_q        <= '0;
      blocks_q     <= '0;
      level_q      <= '0;
      full_q       <= 1'b0;
      acc_q        <= 1'b0;
      done_q       <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_blocks_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_SQ;
          end
        end
        S_SQ: state_q <= S_ACC;
        S_ACC: begin
          full_q <= full_n;
          acc_q  <= rec;
          done_q <= rec & last;
          if (rec & last) begin
            sum_q    <= '0;
            idx_q    <= '0;
            blocks_q <= blocks_q + 1'b1;
            state_q  <= S_LVL;
          end else begin
            if (rec) begin
              sum_q <= sum_n;
              idx_q <= idx_q + 1'b1;
            end
            state_q <= S_OUT;
          end
        end
        S_LVL: begin
          if (lvl_stat.done) begin
            level_q <= lvl_stat.level;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && s_axis_tvalid) begin
      mono_q <= pair_sum[SAMPLE_W:1];
    end
    if (state_q == S_SQ) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
    if (out_load) begin
      m_data_q <= {full_q, blocks_q, level_q, mono_q};
      m_last_q <= done_q;
      m_user_q <= acc_q;
    end
  end

  assign s_axis_tready   = (state_q == S_IDLE);
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tlast    = m_last_q;
  assign m_axis_tuser[0] = m_user_q;
  assign cfg_ready_o     = 1'b1;

endmodule

// File: hdl/sdrms_level_unit.sv
// Block level engine: integer square root of the block mean square, found by testing
// frames * root^2 against the sum, then scaling to 0..100. One shared subtractor does
// every root step. Depends on sdrms_pkg.
module sdrms_level_unit import sdrms_pkg::*; #(
  parameter int unsigned FRAMES_PER_BLOCK = FRAMES_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [SQ_W+$clog2(FRAMES_PER_BLOCK)-1:0]     sum_i,
  output lvl_stat_t                                    stat_o
);

  localparam int unsigned SUM_W = SQ_W + $clog2(FRAMES_PER_BLOCK);
  localparam int unsigned UW    = SUM_W + 1;
  localparam int unsigned CNT_W = $clog2(ROOT_STEPS);
  localparam logic [SUM_W-1:0] NBIT_INIT = SUM_W'(FRAMES_PER_BLOCK) << (2 * ROOT_STEPS - 2);

  typedef enum logic [1:0] {U_IDLE, U_SQRT, U_SCALE} ustate_e;

  ustate_e             state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SUM_W-1:0]    rem_q;
  logic [SUM_W-1:0]    nres_q;
  logic [SUM_W-1:0]    nbit_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W-1:0]   rbit_q;
  logic                done_q;
  logic [LEVEL_W-1:0]  level_q;

  logic [UW-1:0]       op_a;
  logic [UW-1:0]       op_b;
  logic [UW:0]         diff;
  logic                ge;
  logic [15:0]         rms;
  logic [23:0]         prod;
  logic [LEVEL_W-1:0]  level_calc;

  assign op_a = {1'b0, rem_q};
  assign op_b = {1'b0, nres_q} + {1'b0, nbit_q};
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[UW];

  assign rms        = root_q;
  assign prod       = rms[11:0] * 12'(DIV30_MUL);
  assign level_calc = (rms > 16'(RMS_CLIP)) ? LEVEL_W'(LEVEL_MAX) : prod[22:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      level_q <= '0;
    end else begin
      unique case (state_q)
        U_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            cnt_q   <= CNT_W'(ROOT_STEPS - 1);
            state_q <= U_SQRT;
          end
        end
        U_SQRT: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= U_SCALE;
          end
        end
        U_SCALE: begin
          level_q <= level_calc;
          done_q  <= 1'b1;
          state_q <= U_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          rem_q  <= sum_i;
          nres_q <= '0;
          nbit_q <= NBIT_INIT;
          root_q <= '0;
          rbit_q <= ROOT_W'(1) << (ROOT_W - 1);
        end
      end
      U_SQRT: begin
        if (ge) begin
          rem_q  <= diff[SUM_W-1:0];
          nres_q <= (nres_q >> 1) + nbit_q;
          root_q <= root_q | rbit_q;
        end else begin
          nres_q <= nres_q >> 1;
        end
        nbit_q <= nbit_q >> 2;
        rbit_q <= rbit_q >> 1;
      end
      default: ;
    endcase
  end

  assign stat_o.done  = done_q;
  assign stat_o.level = level_q;

endmodule

// File: hdl/sdrms_checker.sv
// Port-level checks for the stereo downmix block RMS meter, bound to the top level.
// Depends on sdrms_pkg.
module sdrms_checker import sdrms_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [39:0]         m_axis_tdata,
  input  logic                m_axis_tlast,
  input  logic [0:0]          m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_last_recorded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("block end on a dropped item");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[39])
    else $error("item dropped without full flag");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[22:16] <= LEVEL_W'(LEVEL_MAX))
    else $error("level out of range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

endmodule

bind stereo_downmix_block_rms_meter sdrms_checker u_sdrms_checker (.*);
